@@ rtl/etcm_pkg.sv @@
package etcm_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned IndexW = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = CountW + IndexW;
  localparam int unsigned DivSteps = IndexW;
  localparam int unsigned MapEntries = 256;
  localparam longint unsigned Cube255 = 64'd16581375;

  typedef logic [CountW-1:0] count_t;
  typedef logic [IndexW-1:0] index_t;
  typedef logic [NumW-1:0]   num_t;
  typedef logic [3*ChanW-1:0] rgb_t;
  typedef logic [MapEntries-1:0][3*ChanW-1:0] rgb_table_t;

  typedef enum logic [0:0] {
    CFG_COLOR_MAP_SIZE  = 1'b0,
    CFG_ITERATION_LIMIT = 1'b1
  } cfg_index_t;

  // Long division, one quotient bit per pass; elaboration only.
  function automatic longint unsigned floor_div(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Bernstein ramps in t = c/255, exact integer floors; built at elaboration.
  function automatic rgb_table_t build_rgb_table();
    rgb_table_t tbl;
    longint unsigned c;
    longint unsigned d;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    for (int i = 0; i < MapEntries; i++) begin
      c = longint'(i);
      d = 64'd255 - c;
      r = floor_div(64'd9 * d * c * c * c, Cube255);
      g = floor_div(64'd15 * c * c * d * d, Cube255);
      b = floor_div(64'd17 * c * d * d * d, 64'd2 * Cube255);
      tbl[i] = {r[ChanW-1:0], g[ChanW-1:0], b[ChanW-1:0]};
    end
    return tbl;
  endfunction

  localparam rgb_table_t RgbTable = build_rgb_table();

endpackage

@@ rtl/escape_time_colormap_unit.sv @@
// An accepted beat goes through stage 0, stages 1..8 and the output register.
// One beat per cycle when not stalled; the count/limit quotient comes from a
// restoring divider unrolled into 8 stages, one quotient bit per stage.
// Stalls collapse bubbles stage by stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipe and loads map size 256
// and iteration limit 256 (clamped to MAX_ITERATIONS).
module escape_time_colormap_unit
  import etcm_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_index_t        cfg_index,
  input  logic [CountW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CountW-1:0] in_iteration_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IndexW-1:0] out_color_index,
  output logic [ChanW-1:0]  out_red,
  output logic [ChanW-1:0]  out_green,
  output logic [ChanW-1:0]  out_blue,
  output logic              out_in_set
);

  localparam int unsigned LimReset = (MAX_ITERATIONS < 256) ? MAX_ITERATIONS : 256;
  localparam count_t LimResetVal = LimReset[CountW-1:0];
  localparam count_t LimMaxVal =
    (MAX_ITERATIONS > 2047) ? {CountW{1'b1}} : MAX_ITERATIONS[CountW-1:0];

  // Configuration, stored already clamped.
  index_t size_m1_r;
  count_t lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_m1_r <= index_t'(MapEntries - 1);
      lim_r     <= LimResetVal;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_MAP_SIZE: begin
          if (cfg_wdata[8:0] < 9'd2) size_m1_r <= index_t'(1);
          else if (cfg_wdata[8:0] > 9'd256) size_m1_r <= index_t'(MapEntries - 1);
          else size_m1_r <= index_t'(cfg_wdata[8:0] - 9'd1);
        end
        CFG_ITERATION_LIMIT: begin
          if (cfg_wdata == '0) lim_r <= count_t'(1);
          else if (32'(cfg_wdata) > MAX_ITERATIONS) lim_r <= LimMaxVal;
          else lim_r <= cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  // Stage 0 holds the numerator; stages 1..DivSteps each resolve one bit.
  logic   v_r   [DivSteps+1];
  logic   set_r [DivSteps+1];
  num_t   rem_r [DivSteps+1];
  index_t q_r   [DivSteps+1];
  logic [DivSteps:0] en;
  logic   adv_out;
  logic   out_valid_r;
  logic   out_in_set_r;
  index_t out_index_r;
  rgb_t   out_rgb_r;

  assign adv_out = !out_valid_r || !out_stall;

  always_comb begin
    en[DivSteps] = !v_r[DivSteps] || adv_out;
    for (int k = DivSteps - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  logic set_nxt;
  num_t num_nxt;

  always_comb begin
    set_nxt = (in_iteration_count >= lim_r);
    num_nxt = set_nxt ? '0 : num_t'(in_iteration_count) * num_t'(size_m1_r);
  end

  num_t   rem_nxt [DivSteps];
  index_t q_nxt   [DivSteps];

  // Restoring step: try the divisor shifted to this stage's quotient bit.
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      num_t dsh;
      dsh = num_t'(lim_r) << (DivSteps - 1 - k);
      rem_nxt[k] = rem_r[k];
      q_nxt[k]   = q_r[k];
      if (rem_r[k] >= dsh) begin
        rem_nxt[k] = rem_r[k] - dsh;
        q_nxt[k][DivSteps-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
    if (en[0] && in_valid) begin
      set_r[0] <= set_nxt;
      rem_r[0] <= num_nxt;
      q_r[0]   <= '0;
    end
    for (int k = 0; k < DivSteps; k++) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en[k+1]) begin
        v_r[k+1] <= v_r[k];
      end
      if (en[k+1] && v_r[k]) begin
        set_r[k+1] <= set_r[k];
        rem_r[k+1] <= rem_nxt[k];
        q_r[k+1]   <= q_nxt[k];
      end
    end
  end

  // Output beat: palette lookup, or black on the last entry when in the set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= v_r[DivSteps];
    end
    if (adv_out && v_r[DivSteps]) begin
      out_in_set_r <= set_r[DivSteps];
      out_index_r  <= set_r[DivSteps] ? size_m1_r : q_r[DivSteps];
      out_rgb_r    <= set_r[DivSteps] ? '0 : RgbTable[q_r[DivSteps]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_in_set      = out_in_set_r;
  assign out_color_index = out_index_r;
  assign out_red         = out_rgb_r[3*ChanW-1:2*ChanW];
  assign out_green       = out_rgb_r[2*ChanW-1:ChanW];
  assign out_blue        = out_rgb_r[ChanW-1:0];

  a_escape_below_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_set_r) |-> (out_index_r < size_m1_r))
    else $error("escaping beat reached the last colormap entry");

  a_in_set_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_in_set_r) |-> (out_rgb_r == '0 && out_index_r == size_m1_r))
    else $error("in-set beat not black on the last entry");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted beat missing from first stage");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DivSteps] && en[DivSteps]) |=> out_valid_r)
    else $error("beat lost between divider and output");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb
  import etcm_pkg::*;
;

  localparam int unsigned MaxIter    = 1024;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRows    = 29;
  localparam int unsigned NumPhases  = 4;
  localparam int unsigned Settings   = 5;
  localparam int unsigned PerSetting = 30;

  typedef struct packed {
    index_t     color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_set;
  } pixel_t;

  typedef struct {
    logic       is_cfg;
    cfg_index_t reg_sel;
    count_t     value;
    logic       typed;
    pixel_t     want;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = CFG_COLOR_MAP_SIZE;
  count_t      cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  count_t      in_iteration_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  index_t      out_color_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_in_set;

  logic [8:0]  map_size_shadow = 9'd256;
  count_t      limit_shadow = 11'd256;
  pixel_t      pending_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Typed rows hold results that follow straight from the formulas; the rest are predicted.
  stim_row_t stim_rows [NumRows] = '{
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd0,     1'b1, '{8'd0,   8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1,     1'b1, '{8'd0,   8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd128,   1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd255,   1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd256,   1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1024,  1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd2047,  1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b1, CFG_COLOR_MAP_SIZE,  11'd2,     1'b0, '0},
    '{1'b1, CFG_ITERATION_LIMIT, 11'd1,     1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd0,     1'b1, '{8'd0,   8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1,     1'b1, '{8'd1,   8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd2047,  1'b1, '{8'd1,   8'd0, 8'd0, 8'd0, 1'b1}},
    // size field masks to 1, then clamps up to 2; limit 0 clamps up to 1
    '{1'b1, CFG_COLOR_MAP_SIZE,  11'h601,   1'b0, '0},
    '{1'b1, CFG_ITERATION_LIMIT, 11'd0,     1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd0,     1'b1, '{8'd0,   8'd0, 8'd0, 8'd0, 1'b0}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1,     1'b1, '{8'd1,   8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b1, CFG_COLOR_MAP_SIZE,  11'd511,   1'b0, '0},
    '{1'b1, CFG_ITERATION_LIMIT, 11'd2047,  1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1023,  1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1024,  1'b1, '{8'd255, 8'd0, 8'd0, 8'd0, 1'b1}},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd512,   1'b0, '0},
    '{1'b1, CFG_COLOR_MAP_SIZE,  11'd300,   1'b0, '0},
    '{1'b1, CFG_ITERATION_LIMIT, 11'd1500,  1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd700,   1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1,     1'b0, '0},
    '{1'b1, CFG_COLOR_MAP_SIZE,  11'd256,   1'b0, '0},
    '{1'b1, CFG_ITERATION_LIMIT, 11'd1024,  1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd1000,  1'b0, '0},
    '{1'b0, CFG_COLOR_MAP_SIZE,  11'd341,   1'b0, '0}
  };

  escape_time_colormap_unit #(
    .MAX_ITERATIONS(MaxIter)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_iteration_count(in_iteration_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_color_index   (out_color_index),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_in_set        (out_in_set)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned map_entries();
    int unsigned s;
    s = map_size_shadow;
    if (s < 2) s = 2;
    if (s > 256) s = 256;
    return s;
  endfunction

  function automatic int unsigned iter_limit();
    int unsigned l;
    l = limit_shadow;
    if (l < 1) l = 1;
    if (l > MaxIter) l = MaxIter;
    return l;
  endfunction

  // Colour of one pixel under the current register settings.
  function automatic pixel_t predict_pixel(count_t count);
    longint unsigned size;
    longint unsigned lim;
    longint unsigned c;
    longint unsigned d;
    longint unsigned cube;
    pixel_t px;
    size = map_entries();
    lim  = iter_limit();
    cube = 64'd255 * 64'd255 * 64'd255;
    if (count >= lim) begin
      px = '{index_t'(size - 1), 8'd0, 8'd0, 8'd0, 1'b1};
    end else begin
      c = (longint'(count) * (size - 1)) / lim;
      d = 64'd255 - c;
      px.color_index = index_t'(c);
      px.red         = 8'((64'd9 * d * c * c * c) / cube);
      px.green       = 8'((64'd15 * c * c * d * d) / cube);
      px.blue        = 8'((64'd17 * c * d * d * d) / (64'd2 * cube));
      px.in_set      = 1'b0;
    end
    return px;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Drain the pipe first; registers only change while nothing is in flight.
  task automatic write_reg(cfg_index_t sel, count_t data);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_COLOR_MAP_SIZE) map_size_shadow = data[8:0];
    else limit_shadow = data;
    @(negedge clk);
  endtask

  task automatic send_count(count_t cnt, pixel_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pending_pixels.push_back(want);
    in_valid           <= 1'b1;
    in_iteration_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic count_t pick_map_size();
    logic [8:0] s;
    case ($urandom_range(0, 5))
      0: s = 9'd2;
      1: s = 9'd256;
      2: s = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 1)) : 9'($urandom_range(257, 511));
      default: s = 9'($urandom_range(2, 256));
    endcase
    // upper data bits fall outside the register and must be dropped
    if ($urandom_range(0, 3) == 0) return {2'($urandom_range(0, 3)), s};
    return {2'b00, s};
  endfunction

  function automatic count_t pick_limit();
    case ($urandom_range(0, 5))
      0: return 11'd1;
      1: return 11'd1024;
      2: return ($urandom_range(0, 1) != 0) ? 11'd0 : 11'($urandom_range(1025, 2047));
      3: return 11'($urandom_range(1, 16));
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat with no expectation: index %0d", out_color_index);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("color_index", want.color_index, out_color_index);
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("in_set", want.in_set, out_in_set);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    count_t      cnt;
    int unsigned lim;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_reg(stim_rows[i].reg_sel, stim_rows[i].value);
      else send_count(stim_rows[i].value,
                      stim_rows[i].typed ? stim_rows[i].want : predict_pixel(stim_rows[i].value));
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int s = 0; s < Settings; s++) begin
        write_reg(CFG_COLOR_MAP_SIZE, pick_map_size());
        write_reg(CFG_ITERATION_LIMIT, pick_limit());
        lim = iter_limit();
        for (int n = 0; n < PerSetting; n++) begin
          // mostly escaping counts, some in the set, some anywhere in the field
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cnt = count_t'($urandom_range(0, lim - 1));
            6, 7: cnt = count_t'($urandom_range(lim, 2047));
            default: cnt = count_t'($urandom_range(0, 2047));
          endcase
          send_count(cnt, predict_pixel(cnt));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // let any stray beat show up before the verdict
    repeat (12) @(negedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
